// ----- sv/sbbs_pkg.sv -----
// Shared types and codes for the sparse bitmap bit store.
// Holds operation and status codes and the cell control/status structs.
// No dependencies; used by sbbs_cell and sparse_bitmap_bit_store.
`default_nettype none

package sbbs_pkg;

    localparam int OP_W  = 2;
    localparam int IDX_W = 32;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_TEST  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

    // Update command broadcast to every cell on the commit cycle
    typedef struct packed {
        logic ins;      // insert a new node at the sorted position
        logic del;      // drop the hit node, close the gap
        logic wr;       // rewrite the hit node's word
        logic set_op;   // wr sets the bit (else clears it)
    } cell_cmd_t;

    // Per-cell flags captured at compare time, reduced by the top level
    typedef struct packed {
        logic hit;       // occupied and block start matches
        logic after;     // occupied and block start not below the key
        logic bit_set;   // selected bit of this word is one
        logic clr_zero;  // word would be zero with the bit cleared
        logic last_hit;  // hit and this is the highest occupied cell
    } cell_stat_t;

endpackage

`default_nettype wire

// ----- sv/sparse_bitmap_bit_store.sv -----
// Sparse bitmap bit store top level: handshakes, control and the node chain.
// Depends on sbbs_pkg and sbbs_cell.
//
// Keeps a sparse bitmap over a 32-bit bit index as up to MAX_NODES nodes,
// each an aligned MAP_BITS-bit block start plus its word, sorted ascending in
// a row of cells. Each input word tests, sets or clears one bit and yields
// exactly one result word carrying the bit value, a status, the node count
// and the high bit (one past the highest node's block, 0 when empty). On
// accept every cell compares its block start with the key in parallel and
// latches its flags; once the output register is free, the flags are reduced,
// the chain inserts (shifting up), drops (shifting down) or rewrites one
// node, and the result is loaded into the output register. A result left
// waiting holds the update cycle, but the next word is taken while the
// previous result still sits in the output register. Set or clear in the
// last block of the index space reports overflow and changes nothing; a set
// needing a new node with the table full reports table full. A test above the
// high bit returns 0. Operation code 3 is ignored and returns status ok.
`default_nettype none

module sparse_bitmap_bit_store #(
    parameter int MAX_NODES = 64,
    parameter int MAP_BITS  = 64,
    localparam int CW       = $clog2(MAX_NODES + 1),
    localparam int OFS_W    = $clog2(MAP_BITS),
    localparam int BW       = 32 - OFS_W
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire [sbbs_pkg::OP_W-1:0]      s_operation,
    input  wire [sbbs_pkg::IDX_W-1:0]     s_bit_index,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic                          m_bit_value,
    output logic [sbbs_pkg::ST_W-1:0]     m_status,
    output logic [CW-1:0]                 m_node_count,
    output logic [sbbs_pkg::IDX_W-1:0]    m_high_bit
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    logic                          state_reg, state_next;
    logic [sbbs_pkg::OP_W-1:0]     op_reg;
    logic [BW-1:0]                 blk_reg;
    logic [OFS_W-1:0]              ofs_reg;
    logic [CW-1:0]                 count_reg, count_next;
    logic [sbbs_pkg::IDX_W-1:0]    end_reg, end_next;

    logic                          m_valid_reg;
    logic                          m_bit_value_reg;
    logic [sbbs_pkg::ST_W-1:0]     m_status_reg;
    logic [CW-1:0]                 m_node_count_reg;
    logic [sbbs_pkg::IDX_W-1:0]    m_high_bit_reg;

    logic                          accept, commit;
    logic [BW-1:0]                 cmp_blk;
    logic [MAP_BITS-1:0]           cmp_sel, upd_sel;
    sbbs_pkg::cell_cmd_t           cmd;

    // Chain links
    logic [BW-1:0]                 start_w  [MAX_NODES];
    logic [MAP_BITS-1:0]           word_w   [MAX_NODES];
    logic                          before_w [MAX_NODES];
    logic                          after_w  [MAX_NODES];
    logic [BW-1:0]                 tail2_w  [MAX_NODES];
    sbbs_pkg::cell_stat_t          stat_w   [MAX_NODES];

    // Reduced flags
    logic                          any_hit, any_after, any_bit, hit_zero, hit_last;
    logic [BW-1:0]                 prev_start;
    logic                          is_set, is_clr, fits, full;
    logic                          do_ins, do_del;
    logic                          res_bit;
    logic [sbbs_pkg::ST_W-1:0]     res_status;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign commit  = (state_reg == S_UPD) && (!m_valid_reg || m_ready);

    assign cmp_blk = s_bit_index[sbbs_pkg::IDX_W-1:OFS_W];
    assign cmp_sel = MAP_BITS'(1) << s_bit_index[OFS_W-1:0];
    assign upd_sel = MAP_BITS'(1) << ofs_reg;

    // Row of node cells; cell 0 sees an always-before left edge
    for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
        logic [BW-1:0]       l_start, r_start;
        logic [MAP_BITS-1:0] l_word, r_word;
        logic                l_before, l_after;

        if (g == 0) begin : g_left_edge
            assign l_start  = '0;
            assign l_word   = '0;
            assign l_before = 1'b1;
            assign l_after  = 1'b0;
        end else begin : g_left
            assign l_start  = start_w[g-1];
            assign l_word   = word_w[g-1];
            assign l_before = before_w[g-1];
            assign l_after  = after_w[g-1];
        end

        if (g == MAX_NODES - 1) begin : g_right_edge
            assign r_start = '0;
            assign r_word  = '0;
        end else begin : g_right
            assign r_start = start_w[g+1];
            assign r_word  = word_w[g+1];
        end

        sbbs_cell #(
            .IDX       (g),
            .MAX_NODES (MAX_NODES),
            .MAP_BITS  (MAP_BITS)
        ) u_cell (
            .aclk          (aclk),
            .count_i       (count_reg),
            .cmp_en_i      (accept),
            .cmp_blk_i     (cmp_blk),
            .cmp_sel_i     (cmp_sel),
            .cmd_i         (cmd),
            .upd_blk_i     (blk_reg),
            .upd_sel_i     (upd_sel),
            .left_start_i  (l_start),
            .left_word_i   (l_word),
            .left_before_i (l_before),
            .left_after_i  (l_after),
            .right_start_i (r_start),
            .right_word_i  (r_word),
            .start_o       (start_w[g]),
            .word_o        (word_w[g]),
            .before_o      (before_w[g]),
            .after_o       (after_w[g]),
            .tail2_o       (tail2_w[g]),
            .stat_o        (stat_w[g])
        );
    end

    // Reduce cell flags; at most one cell hits, one cell holds the second-last node
    always_comb begin
        any_hit    = 1'b0;
        any_after  = 1'b0;
        any_bit    = 1'b0;
        hit_zero   = 1'b0;
        hit_last   = 1'b0;
        prev_start = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            any_hit    = any_hit   | stat_w[i].hit;
            any_after  = any_after | stat_w[i].after;
            any_bit    = any_bit   | (stat_w[i].hit & stat_w[i].bit_set);
            hit_zero   = hit_zero  | (stat_w[i].hit & stat_w[i].clr_zero);
            hit_last   = hit_last  | stat_w[i].last_hit;
            prev_start = prev_start | tail2_w[i];
        end
    end

    assign is_set = (op_reg == sbbs_pkg::OP_SET);
    assign is_clr = (op_reg == sbbs_pkg::OP_CLEAR);
    assign fits   = ~&blk_reg;
    assign full   = (count_reg == CW'(MAX_NODES));
    assign do_ins = commit && fits && is_set && !any_hit && !full;
    assign do_del = commit && fits && is_clr && any_hit && hit_zero;

    assign cmd.ins    = do_ins;
    assign cmd.del    = do_del;
    assign cmd.wr     = commit && fits && (is_set || is_clr) && any_hit;
    assign cmd.set_op = is_set;

    // A hit implies the block lies below the high bit, so no extra range check
    assign res_bit = (op_reg == sbbs_pkg::OP_TEST) && any_hit && any_bit;

    always_comb begin
        res_status = sbbs_pkg::ST_OK;
        if ((is_set || is_clr) && !fits) begin
            res_status = sbbs_pkg::ST_OVERFLOW;
        end else if (is_set && !any_hit && full) begin
            res_status = sbbs_pkg::ST_FULL;
        end
    end

    // Advance count and high bit: append moves the end up, dropping the top node
    // moves it down to the node below (or to zero when the table empties)
    always_comb begin
        count_next = count_reg;
        end_next   = end_reg;
        if (do_ins) begin
            count_next = count_reg + CW'(1);
            if (!any_after) begin
                end_next = {blk_reg, {OFS_W{1'b0}}} + sbbs_pkg::IDX_W'(MAP_BITS);
            end
        end else if (do_del) begin
            count_next = count_reg - CW'(1);
            if (hit_last) begin
                end_next = (count_reg >= CW'(2))
                         ? {prev_start, {OFS_W{1'b0}}} + sbbs_pkg::IDX_W'(MAP_BITS)
                         : '0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            end_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            end_reg   <= end_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the request for the update cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_operation;
            blk_reg <= cmp_blk;
            ofs_reg <= s_bit_index[OFS_W-1:0];
        end
        if (commit) begin
            m_bit_value_reg  <= res_bit;
            m_status_reg     <= res_status;
            m_node_count_reg <= count_next;
            m_high_bit_reg   <= end_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_bit_value  = m_bit_value_reg;
    assign m_status     = m_status_reg;
    assign m_node_count = m_node_count_reg;
    assign m_high_bit   = m_high_bit_reg;

endmodule

`default_nettype wire

// ----- sv/sbbs_cell.sv -----
// One node slot of the sorted node chain: block start, bit word, compare flags.
// Depends on sbbs_pkg for cell_cmd_t and cell_stat_t.
`default_nettype none

module sbbs_cell #(
    parameter int IDX       = 0,
    parameter int MAX_NODES = 64,
    parameter int MAP_BITS  = 64,
    localparam int CW       = $clog2(MAX_NODES + 1),
    localparam int OFS_W    = $clog2(MAP_BITS),
    localparam int BW       = 32 - OFS_W
) (
    input  wire                  aclk,
    input  wire [CW-1:0]         count_i,
    input  wire                  cmp_en_i,
    input  wire [BW-1:0]         cmp_blk_i,
    input  wire [MAP_BITS-1:0]   cmp_sel_i,
    input  sbbs_pkg::cell_cmd_t  cmd_i,
    input  wire [BW-1:0]         upd_blk_i,
    input  wire [MAP_BITS-1:0]   upd_sel_i,
    input  wire [BW-1:0]         left_start_i,
    input  wire [MAP_BITS-1:0]   left_word_i,
    input  wire                  left_before_i,
    input  wire                  left_after_i,
    input  wire [BW-1:0]         right_start_i,
    input  wire [MAP_BITS-1:0]   right_word_i,
    output logic [BW-1:0]        start_o,
    output logic [MAP_BITS-1:0]  word_o,
    output logic                 before_o,
    output logic                 after_o,
    output logic [BW-1:0]        tail2_o,
    output sbbs_pkg::cell_stat_t stat_o
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [BW-1:0]       start_reg, start_next;
    logic [MAP_BITS-1:0] word_reg, word_next;
    logic                lt_reg, eq_reg, bit_reg, zero_reg;
    logic                occ;

    assign occ = IDX_C < count_i;

    always_ff @(posedge aclk) begin
        if (cmp_en_i) begin
            lt_reg   <= start_reg < cmp_blk_i;
            eq_reg   <= start_reg == cmp_blk_i;
            bit_reg  <= |(word_reg & cmp_sel_i);
            zero_reg <= (word_reg & ~cmp_sel_i) == '0;
        end
        start_reg <= start_next;
        word_reg  <= word_next;
    end

    always_comb begin
        start_next = start_reg;
        word_next  = word_reg;
        if (cmd_i.ins) begin
            if (left_after_i) begin
                start_next = left_start_i;
                word_next  = left_word_i;
            end else if (left_before_i && !(occ && lt_reg)) begin
                start_next = upd_blk_i;
                word_next  = upd_sel_i;
            end
        end else if (cmd_i.del) begin
            if (occ && !lt_reg) begin
                start_next = right_start_i;
                word_next  = right_word_i;
            end
        end else if (cmd_i.wr && occ && eq_reg) begin
            word_next = cmd_i.set_op ? (word_reg | upd_sel_i) : (word_reg & ~upd_sel_i);
        end
    end

    assign start_o  = start_reg;
    assign word_o   = word_reg;
    assign before_o = occ && lt_reg;
    assign after_o  = occ && !lt_reg;
    assign tail2_o  = (IDX_C == count_i - CW'(2)) ? start_reg : '0;

    assign stat_o.hit      = occ && eq_reg;
    assign stat_o.after    = occ && !lt_reg;
    assign stat_o.bit_set  = bit_reg;
    assign stat_o.clr_zero = zero_reg;
    assign stat_o.last_hit = occ && eq_reg && (IDX_C == count_i - CW'(1));

endmodule

`default_nettype wire
